// File: hw/rtl/dq_pkg.sv
// Package for the double-ended queue: request and result words, codes, defaults.
`default_nettype none
package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] push_value;
    logic [7:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [8:0]  count;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/dq_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module dq_ram #(
  parameter int unsigned WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue: ring buffer pointers over a single-port RAM.
// The result strobe is registered and comes in the cycle after the request is taken.
// Throughput: one request per cycle; the RAM port does the one access each word needs.
// busy_o stays low: a write lands before the next cycle's read, so no interlock.
// Reset clears the front pointer, the element count, the result strobe and the read-valid flag.
// Storage is not cleared; only entries that were written are ever read.
`default_nettype none
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire dq_pkg::req_t req_i,
  output logic              res_valid_o,
  output dq_pkg::res_t      res_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = (AW + 1)'(base) + (AW + 1)'(off);
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  res_valid_q;
  logic [1:0]            status_q, status_d;
  logic [8:0]            res_count_q;
  logic                  rd_ok_q, rd_ok_d;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [AW-1:0]         front_dec;

  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign ram_wdata = DATA_WIDTH'(req_i.push_value);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = dq_pkg::ST_OK;
    rd_ok_d  = 1'b0;
    ram_we   = 1'b0;
    ram_addr = front_q;
    if (accept) begin
      unique case (req_i.kind)
        dq_pkg::KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            front_d  = front_dec;
            ram_addr = front_dec;
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        dq_pkg::KIND_PUSH_BACK: begin
          if (full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            ram_addr = wrap(front_q, AW'(count_q));
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          if (empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            ram_addr = front_q;
            rd_ok_d  = 1'b1;
            count_d  = count_q - CW'(1);
            front_d  = (count_q == CW'(1)) ? '0 : wrap(front_q, AW'(1));
          end
        end
        dq_pkg::KIND_POP_BACK: begin
          if (empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            ram_addr = wrap(front_q, AW'(count_q - CW'(1)));
            rd_ok_d  = 1'b1;
            count_d  = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              front_d = '0;
            end
          end
        end
        dq_pkg::KIND_READ: begin
          if (CMPW'(req_i.position) >= CMPW'(count_q)) begin
            status_d = dq_pkg::ST_RANGE;
          end else begin
            ram_addr = wrap(front_q, AW'(req_i.position));
            rd_ok_d  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      res_valid_q <= accept;
      rd_ok_q     <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    res_count_q <= 9'(count_d);
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o.read_value = rd_ok_q ? 32'(ram_rdata) : '0;
    res_o.status     = status_q;
    res_o.count      = res_count_q;
  end

endmodule
`default_nettype wire

// File: hw/rtl/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none
module dq_checker #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         start_i,
  input wire logic         busy_o,
  input wire dq_pkg::req_t req_i,
  input wire logic         res_valid_o,
  input wire dq_pkg::res_t res_o
);

  // one result word per request, in the cycle after it
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (res_valid_o == $past(start_i && !busy_o)))
    else $error("result strobe does not follow the request");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != dq_pkg::ST_OK) |-> (res_o.read_value == '0))
    else $error("nonzero value on error");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == dq_pkg::ST_EMPTY) |-> (res_o.count == '0))
    else $error("empty status with nonzero count");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == dq_pkg::ST_FULL) |-> (res_o.count == 9'(DEPTH)))
    else $error("full status with count below depth");

endmodule

bind double_ended_queue_unit dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
`default_nettype wire
